// File: rtl/tsld_pkg.sv
// Shared types, constants and the digit table for the temperature LED driver.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package tsld_pkg;

  localparam int DIGIT_COUNT  = 3;
  localparam int SEGMENT_LEDS = 2;
  localparam int DIGIT_LEDS   = 14;
  localparam int CHAIN_LEDS   = 42;
  localparam int SEG_COUNT    = 7;

  localparam int TEMP_W    = 12;
  localparam int LEVEL_W   = 8;
  localparam int IDX_W     = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CODE_W    = 4;
  localparam int LED_SEL_W = (CHAIN_LEDS > 1) ? $clog2(CHAIN_LEDS) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int NUM_W     = 25;
  localparam int DEN_W     = 17;
  localparam int QUO_W     = 8;
  localparam int DIV_STEPS = 8;
  localparam int STEP_W    = 3;

  localparam logic [CODE_W-1:0] CODE_ZERO  = 4'd0;
  localparam logic [CODE_W-1:0] CODE_BLANK = 4'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS = 3'd0,
    REG_COLD_LIMIT = 3'd1,
    REG_COOL_POINT = 3'd2,
    REG_WARM_POINT = 3'd3,
    REG_HOT_POINT  = 3'd4,
    REG_HOT_LIMIT  = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    SPAN_COLD,
    SPAN_COOL,
    SPAN_WARM,
    SPAN_HOT,
    SPAN_FADE,
    SPAN_RED
  } span_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_CLASS,
    F_LOAD,
    F_DIV,
    F_COLOR,
    F_SCALE,
    F_PUSH
  } front_state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] brightness;
    logic [TEMP_W-1:0]  cold_limit;
    logic [TEMP_W-1:0]  cool_point;
    logic [TEMP_W-1:0]  warm_point;
    logic [TEMP_W-1:0]  hot_point;
    logic [TEMP_W-1:0]  hot_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    brightness: 8'd255,
    cold_limit: 12'hEC0,
    cool_point: 12'h050,
    warm_point: 12'h140,
    hot_point:  12'h230,
    hot_limit:  12'h320
  };

  typedef struct packed {
    logic [LEVEL_W-1:0]    red;
    logic [LEVEL_W-1:0]    green;
    logic [LEVEL_W-1:0]    blue;
    logic [CHAIN_LEDS-1:0] lit;
  } frame_t;

  function automatic logic [SEG_COUNT-1:0] seg_pattern(input logic [CODE_W-1:0] code);
    logic [SEG_COUNT-1:0] pat;
    case (code)
      4'd0:    pat = 7'b1111110;
      4'd1:    pat = 7'b1000010;
      4'd2:    pat = 7'b0110111;
      4'd3:    pat = 7'b1100111;
      4'd4:    pat = 7'b1001011;
      4'd5:    pat = 7'b1101101;
      4'd6:    pat = 7'b1111101;
      4'd7:    pat = 7'b1000110;
      4'd8:    pat = 7'b1111111;
      4'd9:    pat = 7'b1101111;
      default: pat = 7'b0000000;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tsld_front.sv
// Front end: accepts a temperature beat, classifies it into a ramp span, runs
// the ramp division and brightness scaling, and builds the digit LED mask.
// Depends on tsld_pkg.
`default_nettype none

module tsld_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tsld_pkg::cfg_t                cfg,
  input  wire logic [tsld_pkg::TEMP_W-1:0]   temp_sixteenths,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  output logic                               push_valid,
  input  wire logic                          push_ready,
  output tsld_pkg::frame_t                   push_data
);

  tsld_pkg::front_state_t state, state_next;

  logic [tsld_pkg::TEMP_W-1:0]     temp;
  tsld_pkg::span_t                 span;
  logic [tsld_pkg::TEMP_W-1:0]     n_val;
  logic [tsld_pkg::TEMP_W-1:0]     d_val;
  logic                            negative;
  logic [tsld_pkg::CODE_W-1:0]     tens;
  logic [tsld_pkg::CODE_W-1:0]     ones;
  logic [tsld_pkg::CHAIN_LEDS-1:0] lit;
  logic [tsld_pkg::NUM_W-1:0]      rem;
  logic [tsld_pkg::NUM_W-2:0]      dsh;
  logic [tsld_pkg::QUO_W-1:0]      quo;
  logic [tsld_pkg::STEP_W-1:0]     step;
  logic [tsld_pkg::LEVEL_W-1:0]    red;
  logic [tsld_pkg::LEVEL_W-1:0]    green;
  logic [tsld_pkg::LEVEL_W-1:0]    blue;
  logic [2*tsld_pkg::LEVEL_W-1:0]  prod_r;
  logic [2*tsld_pkg::LEVEL_W-1:0]  prod_g;
  logic [2*tsld_pkg::LEVEL_W-1:0]  prod_b;

  logic signed [tsld_pkg::TEMP_W-1:0] t_s;
  tsld_pkg::span_t                    span_c;
  logic [tsld_pkg::TEMP_W-1:0]        lo_c;
  logic [tsld_pkg::TEMP_W-1:0]        hi_c;
  logic [tsld_pkg::TEMP_W:0]          n_c;
  logic [tsld_pkg::TEMP_W:0]          d_c;
  logic [tsld_pkg::TEMP_W-1:0]        abs_c;
  logic [6:0]                         mag_c;
  logic [14:0]                        tens_mul;
  logic [3:0]                         tens_c;
  logic [6:0]                         ones_w;

  logic [tsld_pkg::NUM_W-1:0]   num_c;
  logic [tsld_pkg::DEN_W-1:0]   den_c;
  logic [tsld_pkg::NUM_W-1:0]   n_ext;
  logic [tsld_pkg::NUM_W-1:0]   d_ext;
  logic [tsld_pkg::CHAIN_LEDS-1:0] lit_c;
  logic [tsld_pkg::CODE_W-1:0]  code_c [tsld_pkg::DIGIT_COUNT];
  logic [tsld_pkg::SEG_COUNT-1:0] pat_c [tsld_pkg::DIGIT_COUNT];

  logic                         ge;
  logic [tsld_pkg::LEVEL_W-1:0] red_c;
  logic [tsld_pkg::LEVEL_W-1:0] green_c;
  logic [tsld_pkg::LEVEL_W-1:0] blue_c;

  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  // classify, plus span offsets and the tens/ones digits
  always_comb begin
    t_s    = $signed(temp);
    span_c = tsld_pkg::SPAN_RED;
    lo_c   = cfg.hot_point;
    hi_c   = cfg.hot_limit;
    if (t_s <= $signed(cfg.cold_limit)) begin
      span_c = tsld_pkg::SPAN_COLD;
    end else if (t_s < $signed(cfg.cool_point)) begin
      span_c = tsld_pkg::SPAN_COOL;
      lo_c   = cfg.cold_limit;
      hi_c   = cfg.cool_point;
    end else if (t_s < $signed(cfg.warm_point)) begin
      span_c = tsld_pkg::SPAN_WARM;
      lo_c   = cfg.cool_point;
      hi_c   = cfg.warm_point;
    end else if (t_s < $signed(cfg.hot_point)) begin
      span_c = tsld_pkg::SPAN_HOT;
      lo_c   = cfg.warm_point;
      hi_c   = cfg.hot_point;
    end else if (t_s < $signed(cfg.hot_limit)) begin
      span_c = tsld_pkg::SPAN_FADE;
    end
    n_c = {temp[tsld_pkg::TEMP_W-1], temp} - {lo_c[tsld_pkg::TEMP_W-1], lo_c};
    d_c = {hi_c[tsld_pkg::TEMP_W-1], hi_c} - {lo_c[tsld_pkg::TEMP_W-1], lo_c};

    abs_c    = temp[tsld_pkg::TEMP_W-1] ? (12'd0 - temp) : temp;
    mag_c    = (abs_c[11:4] > 8'd99) ? 7'd99 : abs_c[10:4];
    tens_mul = {8'd0, mag_c} * 15'd205;
    tens_c   = tens_mul[14:11];
    ones_w   = mag_c - ({3'd0, tens_c} * 7'd10);
  end

  // divider operands and digit mask
  always_comb begin
    n_ext = {13'd0, n_val};
    d_ext = {13'd0, d_val};
    case (span)
      tsld_pkg::SPAN_COOL, tsld_pkg::SPAN_WARM: begin
        num_c = n_ext * 25'd255;
        den_c = {5'd0, d_val};
      end
      tsld_pkg::SPAN_HOT: begin
        num_c = (d_ext * 25'd5100) - (n_ext * 25'd1785);
        den_c = {5'd0, d_val} * 17'd20;
      end
      tsld_pkg::SPAN_FADE: begin
        num_c = (d_ext - n_ext) * 25'd165;
        den_c = {5'd0, d_val};
      end
      default: begin
        num_c = '0;
        den_c = {5'd0, d_val};
      end
    endcase

    lit_c = '0;
    for (int k = 0; k < tsld_pkg::DIGIT_COUNT; k++) begin
      if (negative) begin
        code_c[k] = (k == 0) ? tens : (k == 1) ? ones : tsld_pkg::CODE_BLANK;
      end else begin
        code_c[k] = (k == 0) ? tsld_pkg::CODE_ZERO : (k == 1) ? tens : ones;
      end
      pat_c[k] = tsld_pkg::seg_pattern(code_c[k]);
      for (int s = 0; s < tsld_pkg::SEG_COUNT; s++) begin
        for (int j = 0; j < tsld_pkg::SEGMENT_LEDS; j++) begin
          if (k * tsld_pkg::DIGIT_LEDS + s * tsld_pkg::SEGMENT_LEDS + j
              < tsld_pkg::CHAIN_LEDS) begin
            if (pat_c[k][s]) begin
              lit_c[k * tsld_pkg::DIGIT_LEDS + s * tsld_pkg::SEGMENT_LEDS + j] = 1'b1;
            end
          end
        end
      end
    end
  end

  // divider compare, and ramp colour per span (from the quotient where it ramps)
  always_comb begin
    ge      = rem >= {1'b0, dsh};
    red_c   = 8'd255;
    green_c = 8'd0;
    blue_c  = 8'd0;
    case (span)
      tsld_pkg::SPAN_COLD: begin
        red_c   = 8'd0;
        green_c = 8'd255;
      end
      tsld_pkg::SPAN_COOL: begin
        red_c   = 8'd0;
        green_c = 8'd255;
        blue_c  = quo;
      end
      tsld_pkg::SPAN_WARM: begin
        red_c   = quo;
        green_c = 8'd255;
        blue_c  = 8'd255 - quo - {7'd0, (rem != '0)};
      end
      tsld_pkg::SPAN_HOT, tsld_pkg::SPAN_FADE: begin
        green_c = quo;
      end
      default: begin
        green_c = 8'd0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      tsld_pkg::F_IDLE:  if (in_valid) state_next = tsld_pkg::F_CLASS;
      tsld_pkg::F_CLASS: state_next = tsld_pkg::F_LOAD;
      tsld_pkg::F_LOAD:  state_next = tsld_pkg::F_DIV;
      tsld_pkg::F_DIV: begin
        if (step == tsld_pkg::STEP_W'(tsld_pkg::DIV_STEPS - 1)) begin
          state_next = tsld_pkg::F_COLOR;
        end
      end
      tsld_pkg::F_COLOR: state_next = tsld_pkg::F_SCALE;
      tsld_pkg::F_SCALE: state_next = tsld_pkg::F_PUSH;
      tsld_pkg::F_PUSH:  if (push_ready) state_next = tsld_pkg::F_IDLE;
      default:           state_next = tsld_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == tsld_pkg::F_IDLE);
    push_valid = (state == tsld_pkg::F_PUSH);
    push_data.red   = div255(prod_r);
    push_data.green = div255(prod_g);
    push_data.blue  = div255(prod_b);
    push_data.lit   = lit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsld_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      tsld_pkg::F_IDLE: begin
        if (in_valid) temp <= temp_sixteenths;
      end
      tsld_pkg::F_CLASS: begin
        span     <= span_c;
        n_val    <= n_c[tsld_pkg::TEMP_W-1:0];
        d_val    <= d_c[tsld_pkg::TEMP_W-1:0];
        negative <= temp[tsld_pkg::TEMP_W-1];
        tens     <= tens_c;
        ones     <= ones_w[3:0];
      end
      tsld_pkg::F_LOAD: begin
        rem  <= num_c;
        dsh  <= {den_c, 7'd0};
        quo  <= '0;
        step <= '0;
        lit  <= lit_c;
      end
      tsld_pkg::F_DIV: begin
        if (ge) rem <= rem - {1'b0, dsh};
        quo  <= {quo[tsld_pkg::QUO_W-2:0], ge};
        dsh  <= dsh >> 1;
        step <= step + 1'b1;
      end
      tsld_pkg::F_COLOR: begin
        red   <= red_c;
        green <= green_c;
        blue  <= blue_c;
      end
      tsld_pkg::F_SCALE: begin
        prod_r <= {8'd0, red} * {8'd0, cfg.brightness};
        prod_g <= {8'd0, green} * {8'd0, cfg.brightness};
        prod_b <= {8'd0, blue} * {8'd0, cfg.brightness};
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/tsld_queue.sv
// Two-entry frame queue between the front end and the LED emitter.
// Depends on tsld_pkg.
`default_nettype none

module tsld_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire tsld_pkg::frame_t push_data,
  output logic                  pop_valid,
  input  wire logic             pop,
  output tsld_pkg::frame_t      head
);

  tsld_pkg::frame_t              mem [tsld_pkg::QUEUE_DEPTH];
  logic [tsld_pkg::QPTR_W-1:0]   wr_ptr;
  logic [tsld_pkg::QPTR_W-1:0]   rd_ptr;
  logic [tsld_pkg::QCNT_W-1:0]   count;
  logic                          do_push;

  assign push_ready = (count != tsld_pkg::QCNT_W'(tsld_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/tsld_back.sv
// LED emitter: walks the chain for the frame at the queue head, one beat per
// LED, through a registered output stage. Depends on tsld_pkg.
`default_nettype none

module tsld_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         pop_valid,
  input  wire tsld_pkg::frame_t             head,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [tsld_pkg::IDX_W-1:0]        led_index,
  output logic [tsld_pkg::LEVEL_W-1:0]      red_level,
  output logic [tsld_pkg::LEVEL_W-1:0]      green_level,
  output logic [tsld_pkg::LEVEL_W-1:0]      blue_level,
  output logic                              last_led
);

  logic [tsld_pkg::LED_SEL_W-1:0] idx;
  logic                           load;
  logic                           at_last;
  logic                           lit_bit;

  assign load    = pop_valid && (!out_valid || out_ready);
  assign at_last = (idx == tsld_pkg::LED_SEL_W'(tsld_pkg::CHAIN_LEDS - 1));
  assign pop     = load && at_last;
  assign lit_bit = head.lit[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= at_last ? '0 : idx + 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      led_index   <= tsld_pkg::IDX_W'(idx);
      red_level   <= lit_bit ? head.red : '0;
      green_level <= lit_bit ? head.green : '0;
      blue_level  <= lit_bit ? head.blue : '0;
      last_led    <= at_last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/temperature_segment_led_driver_unit.sv
// Temperature to seven-segment LED frame driver, top level.
// Throughput: CHAIN_LEDS beats per temperature, one per cycle while out_ready is high, set by the emitter;
// the front end classifies, divides, colours and scales each temperature before it takes the next.
// Reset restores the register defaults, empties the queue and drops out_valid.
// Depends on tsld_pkg, tsld_front, tsld_queue, tsld_back.
`default_nettype none

module temperature_segment_led_driver_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [tsld_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tsld_pkg::TEMP_W-1:0]     cfg_data,
  input  wire logic [tsld_pkg::TEMP_W-1:0]     temp_sixteenths,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  output logic [tsld_pkg::IDX_W-1:0]           led_index,
  output logic [tsld_pkg::LEVEL_W-1:0]         red_level,
  output logic [tsld_pkg::LEVEL_W-1:0]         green_level,
  output logic [tsld_pkg::LEVEL_W-1:0]         blue_level,
  output logic                                 last_led,
  output logic                                 out_valid,
  input  wire logic                            out_ready
);

  tsld_pkg::cfg_t   cfg;
  tsld_pkg::frame_t push_data;
  tsld_pkg::frame_t head;
  logic             push_valid;
  logic             push_ready;
  logic             pop_valid;
  logic             pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= tsld_pkg::CFG_RESET;
    end else if (cfg_write) begin
      case (tsld_pkg::cfg_reg_t'(cfg_index))
        tsld_pkg::REG_BRIGHTNESS: cfg.brightness <= cfg_data[tsld_pkg::LEVEL_W-1:0];
        tsld_pkg::REG_COLD_LIMIT: cfg.cold_limit <= cfg_data;
        tsld_pkg::REG_COOL_POINT: cfg.cool_point <= cfg_data;
        tsld_pkg::REG_WARM_POINT: cfg.warm_point <= cfg_data;
        tsld_pkg::REG_HOT_POINT:  cfg.hot_point  <= cfg_data;
        tsld_pkg::REG_HOT_LIMIT:  cfg.hot_limit  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tsld_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .temp_sixteenths (temp_sixteenths),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_data       (push_data)
  );

  tsld_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .head       (head)
  );

  tsld_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .led_index   (led_index),
    .red_level   (red_level),
    .green_level (green_level),
    .blue_level  (blue_level),
    .last_led    (last_led)
  );

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_index_advances: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_led) |=>
      (out_valid && led_index == $past(led_index) + 6'd1))
    else $error("LED index did not advance within a frame");

  a_frame_restarts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_led) |=> (!out_valid || led_index == '0))
    else $error("new frame did not start at LED zero");

  a_queue_holds_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_led) |-> pop_valid)
    else $error("frame left the queue before its last LED");

endmodule

`default_nettype wire
